[sv/timed_average_decimator_top_defines.svh]
// assertion macros used by the checker file
`ifndef TIMED_AVERAGE_DECIMATOR_TOP_DEFINES_SVH
`define TIMED_AVERAGE_DECIMATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TAD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tad check failed");

// next-cycle implication, sampled on clk, off during reset
`define TAD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tad check failed");

`endif

[sv/tad_pkg.sv]
// shared widths, reset values and types of the timed average decimator
package tad_pkg;

    localparam int VALUE_W = 24;
    localparam int TIME_W = 64;
    localparam int INC_W = 16;
    localparam int SUM_W = 32;
    localparam int CNT_W = 8;
    localparam int MISS_W = 6;
    localparam int DIGIT_W = 4;
    localparam int TIME_DIGITS = TIME_W / DIGIT_W;
    localparam int DIV_STEPS = SUM_W;
    localparam int CYC_W = $clog2(DIV_STEPS);

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 96;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [MISS_W-1:0] MISSED_LIMIT = 6'd50;

    localparam logic [INC_W-1:0] TICK_INC_RST = 16'd256;
    localparam logic [INC_W-1:0] SAMPLE_INT_RST = 16'd4096;

    typedef struct packed {
        logic [INC_W-1:0] tick_increment;
        logic [INC_W-1:0] sample_interval;
        logic             subsample_enable;
        logic             sensor_powered;
    } tad_cfg_t;

    typedef struct packed {
        logic ge;
        logic behind;
    } tad_time_stat_t;

endpackage

[sv/tad_regs.sv]
// apb configuration registers of the timed average decimator
module tad_regs
    import tad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output tad_cfg_t          cfg
);

    localparam logic [1:0] REG_TICK_INC = 2'd0;
    localparam logic [1:0] REG_SAMPLE_INT = 2'd1;
    localparam logic [1:0] REG_SUBSAMPLE = 2'd2;
    localparam logic [1:0] REG_POWERED = 2'd3;

    tad_cfg_t   cfg_reg;
    tad_cfg_t   cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en = psel & penable & pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_TICK_INC:   cfg_next.tick_increment = pwdata[INC_W-1:0];
                REG_SAMPLE_INT: cfg_next.sample_interval = pwdata[INC_W-1:0];
                REG_SUBSAMPLE:  cfg_next.subsample_enable = pwdata[0];
                REG_POWERED:    cfg_next.sensor_powered = pwdata[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_increment <= TICK_INC_RST;
            cfg_reg.sample_interval <= SAMPLE_INT_RST;
            cfg_reg.subsample_enable <= 1'b1;
            cfg_reg.sensor_powered <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TICK_INC:   prdata = {{(APB_DW-INC_W){1'b0}}, cfg_reg.tick_increment};
            REG_SAMPLE_INT: prdata = {{(APB_DW-INC_W){1'b0}}, cfg_reg.sample_interval};
            REG_SUBSAMPLE:  prdata = {{(APB_DW-1){1'b0}}, cfg_reg.subsample_enable};
            REG_POWERED:    prdata = {{(APB_DW-1){1'b0}}, cfg_reg.sensor_powered};
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[sv/tad_time_ser.sv]
// digit-serial tick time and sample schedule unit
module tad_time_ser
    import tad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              step,
    input  logic              commit_nst,
    input  logic [INC_W-1:0]  tick_increment,
    input  logic [INC_W-1:0]  sample_interval,
    output logic [TIME_W-1:0] tick_time,
    output logic [TIME_W-1:0] next_time,
    output tad_time_stat_t    stat
);

    logic [TIME_W-1:0]  tick_reg;
    logic [TIME_W-1:0]  tick_next;
    logic [TIME_W-1:0]  nst_reg;
    logic [TIME_W-1:0]  nst_next;
    logic [TIME_W-1:0]  nst2_reg;
    logic [TIME_W-1:0]  nst2_next;
    logic [TIME_W-1:0]  alt_reg;
    logic [TIME_W-1:0]  alt_next;
    logic [INC_W-1:0]   inc_sr_reg;
    logic [INC_W-1:0]   inc_sr_next;
    logic [INC_W-1:0]   int_sr_reg;
    logic [INC_W-1:0]   int_sr_next;
    logic               c_tick_reg;
    logic               c_tick_next;
    logic               c_nst_reg;
    logic               c_nst_next;
    logic               c_alt_reg;
    logic               c_alt_next;
    logic               b_ge_reg;
    logic               b_ge_next;
    logic               b_lt_reg;
    logic               b_lt_next;

    logic [DIGIT_W-1:0] t_d;
    logic [DIGIT_W-1:0] n_d;
    logic [DIGIT_W-1:0] inc_d;
    logic [DIGIT_W-1:0] int_d;
    logic [DIGIT_W:0]   tick_sum;
    logic [DIGIT_W:0]   nst2_sum;
    logic [DIGIT_W:0]   alt_sum;
    logic [DIGIT_W-1:0] tn_d;
    logic [DIGIT_W-1:0] n2_d;

    assign t_d = tick_reg[DIGIT_W-1:0];
    assign n_d = nst_reg[DIGIT_W-1:0];
    assign inc_d = inc_sr_reg[DIGIT_W-1:0];
    assign int_d = int_sr_reg[DIGIT_W-1:0];

    assign tick_sum = {1'b0, t_d} + {1'b0, inc_d} + {{DIGIT_W{1'b0}}, c_tick_reg};
    assign tn_d = tick_sum[DIGIT_W-1:0];
    assign nst2_sum = {1'b0, n_d} + {1'b0, int_d} + {{DIGIT_W{1'b0}}, c_nst_reg};
    assign n2_d = nst2_sum[DIGIT_W-1:0];
    assign alt_sum = {1'b0, tn_d} + {1'b0, int_d} + {{DIGIT_W{1'b0}}, c_alt_reg};

    always_comb
    begin
        tick_next = tick_reg;
        nst_next = nst_reg;
        nst2_next = nst2_reg;
        alt_next = alt_reg;
        inc_sr_next = inc_sr_reg;
        int_sr_next = int_sr_reg;
        c_tick_next = c_tick_reg;
        c_nst_next = c_nst_reg;
        c_alt_next = c_alt_reg;
        b_ge_next = b_ge_reg;
        b_lt_next = b_lt_reg;
        priority if (start)
        begin
            inc_sr_next = tick_increment;
            int_sr_next = sample_interval;
            c_tick_next = 1'b0;
            c_nst_next = 1'b0;
            c_alt_next = 1'b0;
            b_ge_next = 1'b0;
            b_lt_next = 1'b0;
        end
        else if (step)
        begin
            // lsb-first digit, every sum and compare chain carries one bit to the next digit
            tick_next = {tn_d, tick_reg[TIME_W-1:DIGIT_W]};
            nst_next = {n_d, nst_reg[TIME_W-1:DIGIT_W]};
            nst2_next = {n2_d, nst2_reg[TIME_W-1:DIGIT_W]};
            alt_next = {alt_sum[DIGIT_W-1:0], alt_reg[TIME_W-1:DIGIT_W]};
            inc_sr_next = inc_sr_reg >> DIGIT_W;
            int_sr_next = int_sr_reg >> DIGIT_W;
            c_tick_next = tick_sum[DIGIT_W];
            c_nst_next = nst2_sum[DIGIT_W];
            c_alt_next = alt_sum[DIGIT_W];
            b_ge_next = (tn_d < n_d) | ((tn_d == n_d) & b_ge_reg);
            b_lt_next = (n2_d < tn_d) | ((n2_d == tn_d) & b_lt_reg);
        end
        else if (commit_nst)
        begin
            nst_next = b_lt_reg ? alt_reg : nst2_reg;
        end
        else
        begin
            nst_next = nst_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            nst_reg <= '0;
            c_tick_reg <= 1'b0;
            c_nst_reg <= 1'b0;
            c_alt_reg <= 1'b0;
            b_ge_reg <= 1'b0;
            b_lt_reg <= 1'b0;
        end
        else
        begin
            tick_reg <= tick_next;
            nst_reg <= nst_next;
            c_tick_reg <= c_tick_next;
            c_nst_reg <= c_nst_next;
            c_alt_reg <= c_alt_next;
            b_ge_reg <= b_ge_next;
            b_lt_reg <= b_lt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nst2_reg <= nst2_next;
        alt_reg <= alt_next;
        inc_sr_reg <= inc_sr_next;
        int_sr_reg <= int_sr_next;
    end

    assign tick_time = tick_reg;
    assign next_time = nst2_reg;
    assign stat.ge = ~b_ge_reg;
    assign stat.behind = b_lt_reg;

endmodule

[sv/tad_div_ser.sv]
// bit-serial restoring divider for the interval average
module tad_div_ser
    import tad_pkg::*;
(
    input  logic               clk,
    input  logic               start,
    input  logic               step,
    input  logic [SUM_W-1:0]   dividend,
    input  logic [CNT_W-1:0]   divisor,
    output logic [VALUE_W-1:0] quotient
);

    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] rem_next;
    logic [SUM_W-1:0] q_reg;
    logic [SUM_W-1:0] q_next;
    logic [CNT_W-1:0] div_reg;
    logic [CNT_W-1:0] div_next;
    logic [CNT_W:0]   rem_sh;
    logic [CNT_W:0]   diff;
    logic             fits;

    assign rem_sh = {rem_reg, q_reg[SUM_W-1]};
    assign fits = rem_sh >= {1'b0, div_reg};
    assign diff = rem_sh - {1'b0, div_reg};

    always_comb
    begin
        rem_next = rem_reg;
        q_next = q_reg;
        div_next = div_reg;
        priority if (start)
        begin
            rem_next = '0;
            q_next = dividend;
            div_next = divisor;
        end
        else if (step)
        begin
            rem_next = fits ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            q_next = {q_reg[SUM_W-2:0], fits};
        end
        else
        begin
            q_next = q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg <= q_next;
        div_reg <= div_next;
    end

    // clamp to the 24-bit sample range
    assign quotient = (|q_reg[SUM_W-1:VALUE_W]) ? {VALUE_W{1'b1}} : q_reg[VALUE_W-1:0];

endmodule

[sv/timed_average_decimator_top.sv]
// timed average decimator: one transaction per timer tick, one result per tick
//
// s_tdata[23:0] is the converter sample, s_tuser[0] says a sample came with the tick.
// each accepted tick yields one result transaction on the m_ side: m_tuser[0] marks
// an emitted sample, m_tdata carries value, timestamp, resync and restart flags.
// the tick time and sample schedule are 64-bit values updated 4 bits per cycle; the
// average is a bit-serial divide of 32 steps, which runs beside them. a tick reaches
// the result register at commit, after the 32 divide steps; the input is not ready
// for a new tick until the last one has been committed.
// s_tready is low while a tick is in work and is high again the cycle after commit.
// a waiting result does not block the next tick; only the commit of that tick
// waits until the output register is free, so a stalled receiver holds it there.
// configuration goes through the apb port at byte addresses 0, 4, 8 and 12; the user
// has it written only while idle, the block does not enforce it. reset clears tick
// time, schedule, sum, count and watchdog, loads register defaults; no result pends.
module timed_average_decimator_top
    import tad_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // adc_value
    input  logic [0:0]           s_tuser,   // adc_valid
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // sample_value, sample_time, resync_jump,
                                            // restart_converter, zero fill
    output logic [0:0]           m_tuser,   // sample_valid
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } tad_state_t;

    localparam int PAD_W = M_TDATA_W - (VALUE_W + TIME_W + 2);

    tad_cfg_t          cfg;
    tad_time_stat_t    tstat;
    tad_state_t        state_reg;
    tad_state_t        state_next;
    logic [CYC_W-1:0]  cyc_reg;
    logic [CYC_W-1:0]  cyc_next;

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [MISS_W-1:0] missed_reg;
    logic [MISS_W-1:0] missed_next;
    logic              restart_reg;
    logic              restart_next;
    logic              item_valid_reg;
    logic              item_valid_next;
    logic [VALUE_W-1:0] item_value_reg;
    logic [VALUE_W-1:0] item_value_next;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;
    logic                 m_user_reg;
    logic                 m_user_next;

    logic               in_fire;
    logic               accum;
    logic [SUM_W:0]     sum_ext;
    logic [SUM_W-1:0]   sum_sat;
    logic [CNT_W-1:0]   cnt_inc;
    logic [MISS_W-1:0]  missed_step;
    logic               time_step;
    logic               run_end;
    logic               out_free;
    logic               commit;
    logic               live;
    logic               pass;
    logic               avg_due;
    logic [TIME_W-1:0]  tick_time;
    logic [TIME_W-1:0]  next_time;
    logic [VALUE_W-1:0] avg;
    logic               o_valid;
    logic [VALUE_W-1:0] o_value;
    logic [TIME_W-1:0]  o_time;
    logic               o_jump;

    tad_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire = s_tvalid & s_tready;

    // accumulate and watchdog at acceptance
    assign accum = cfg.sensor_powered & s_tuser[0] & cfg.subsample_enable;
    assign sum_ext = {1'b0, sum_reg} + {{(SUM_W+1-VALUE_W){1'b0}}, s_tdata[VALUE_W-1:0]};
    assign sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    assign cnt_inc = (cnt_reg == {CNT_W{1'b1}}) ? cnt_reg : cnt_reg + {{(CNT_W-1){1'b0}}, 1'b1};
    assign missed_step = s_tuser[0] ? '0 :
                         (missed_reg == {MISS_W{1'b1}}) ? missed_reg :
                         missed_reg + {{(MISS_W-1){1'b0}}, 1'b1};

    assign time_step = (state_reg == ST_RUN) && (cyc_reg < CYC_W'(TIME_DIGITS));
    assign run_end = (state_reg == ST_RUN) && (cyc_reg == CYC_W'(DIV_STEPS - 1));
    assign out_free = ~m_valid_reg | m_tready;
    assign commit = (state_reg == ST_DONE) & out_free;

    tad_time_ser u_time (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (in_fire),
        .step            (time_step),
        .commit_nst      (commit & avg_due),
        .tick_increment  (cfg.tick_increment),
        .sample_interval (cfg.sample_interval),
        .tick_time       (tick_time),
        .next_time       (next_time),
        .stat            (tstat)
    );

    tad_div_ser u_div (
        .clk      (clk),
        .start    (in_fire),
        .step     (state_reg == ST_RUN),
        .dividend (sum_sat),
        .divisor  (cnt_inc),
        .quotient (avg)
    );

    // result selection at commit
    assign live = cfg.sensor_powered & item_valid_reg;
    assign pass = live & ~cfg.subsample_enable;
    assign avg_due = live & cfg.subsample_enable & tstat.ge;

    always_comb
    begin
        o_valid = 1'b0;
        o_value = '0;
        o_time = '0;
        o_jump = 1'b0;
        priority if (pass)
        begin
            o_valid = 1'b1;
            o_value = item_value_reg;
            o_time = tick_time;
        end
        else if (avg_due)
        begin
            o_jump = tstat.behind;
            if (!tstat.behind)
            begin
                o_valid = 1'b1;
                o_value = avg;
                o_time = next_time;
            end
        end
        else
        begin
            o_valid = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cyc_next = cyc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cyc_next = '0;
                if (in_fire)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cyc_next = cyc_reg + {{(CYC_W-1){1'b0}}, 1'b1};
                if (run_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        missed_next = missed_reg;
        restart_next = restart_reg;
        item_valid_next = item_valid_reg;
        item_value_next = item_value_reg;
        if (in_fire)
        begin
            item_valid_next = s_tuser[0];
            item_value_next = s_tdata[VALUE_W-1:0];
            restart_next = 1'b0;
            if (accum)
            begin
                sum_next = sum_sat;
                cnt_next = cnt_inc;
            end
            if (cfg.sensor_powered)
            begin
                if (missed_step > MISSED_LIMIT)
                begin
                    restart_next = 1'b1;
                    missed_next = '0;
                end
                else
                begin
                    missed_next = missed_step;
                end
            end
        end
        else if (commit && avg_due)
        begin
            sum_next = '0;
            cnt_next = '0;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        m_user_next = m_user_reg;
        priority if (commit)
        begin
            m_valid_next = 1'b1;
            m_data_next = {{PAD_W{1'b0}}, restart_reg, o_jump, o_time, o_value};
            m_user_next = o_valid;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cyc_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
            missed_reg <= '0;
            restart_reg <= 1'b0;
            item_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cyc_reg <= cyc_next;
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            missed_reg <= missed_next;
            restart_reg <= restart_next;
            item_valid_reg <= item_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_value_reg <= item_value_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_user_reg;

endmodule

[sv/tad_checker.sv]
// port-level checks of the timed average decimator, bound to the top level
`include "timed_average_decimator_top_defines.svh"

module tad_checker
    import tad_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser
);

    // a stalled result keeps its payload
    `TAD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

    // one tick in work at a time
    `TAD_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // no emitted sample means zero value and zero timestamp
    `TAD_ASSERT_IMP(a_idle_zero, m_tvalid && !m_tuser[0], m_tdata[VALUE_W+TIME_W-1:0] == '0)

    // a resync never comes with an emitted sample
    `TAD_ASSERT_IMP(a_jump_excl, m_tvalid && m_tuser[0], !m_tdata[VALUE_W+TIME_W])

endmodule

bind timed_average_decimator_top tad_checker u_tad_checker (.*);
